/* hdl/tnss_pkg.sv */
// Shared constants, types and tables for the triangle normal and shade setup pipeline.
package tnss_pkg;

  localparam int COORD_BITS       = 12;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int EDGE_W  = COORD_BITS + 1;        // vertex difference
  localparam int PROD_W  = 2 * EDGE_W;            // edge product
  localparam int MAG_W   = 2 * COORD_BITS + 1;    // |cross component|
  localparam int N_W     = MAG_W + 1;             // signed cross component
  localparam int SQ_W    = 2 * MAG_W;             // squared component
  localparam int SUM_W   = SQ_W + 2;              // sum of three squares, even
  localparam int ROOT_W  = SUM_W / 2;             // integer square root
  localparam int REM_W   = ROOT_W + 3;            // root remainder
  localparam int DREM_W  = ROOT_W + 1;            // divider remainder
  localparam int Q_W     = NORMAL_FRAC_BITS + 1;  // quotient, at most 2^frac
  localparam int OUT_W   = 16;
  localparam int SHADE_W = 8;
  localparam int PAL_W   = 8;
  localparam int WIND_W  = 2;

  localparam int IN_TDATA_W  = ((9 * COORD_BITS + WIND_W + PAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 1 + SHADE_W + 7) / 8) * 8;

  localparam logic [WIND_W-1:0] WIND_SWAP   = 2'b11;  // -1
  localparam logic [WIND_W-1:0] WIND_NOCULL = 2'b00;  // 0

  localparam logic [4:0] MAX_COLOR = 5'd31;

  // floor(c * 255 / 31)
  localparam logic [SHADE_W-1:0] SHADE_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vert_t;

  // Per-triangle data that rides along the root and divide stages.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  cull;
    logic [SHADE_W-1:0]    shade;
  } side_t;

endpackage

/* hdl/tnss_front.sv */
// Front stages: vertex swap, edges, cross product, magnitudes, sum of squares.
module tnss_front import tnss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  vert_t             v0,
  input  vert_t             v1,
  input  vert_t             v2,
  input  logic [WIND_W-1:0] winding,
  input  logic [PAL_W-1:0]  palette,
  output logic              out_v,
  output logic [SUM_W-1:0]  sum,
  output side_t             side
);

  // stage 1: edges
  logic                     s1_v_r;
  logic signed [EDGE_W-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic                     s1_cull_r;
  logic [SHADE_W-1:0]       s1_shade_r;
  // stage 2: products
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic                     s2_cull_r;
  logic [SHADE_W-1:0]       s2_shade_r;
  // stage 3: cross components
  logic                     s3_v_r;
  logic signed [N_W-1:0]    n_r [3];
  logic                     s3_cull_r;
  logic [SHADE_W-1:0]       s3_shade_r;
  // stage 4: magnitudes
  logic                     s4_v_r;
  side_t                    s4_side_r;
  // stage 5: squares
  logic                     s5_v_r;
  logic [SQ_W-1:0]          sq_r [3];
  side_t                    s5_side_r;
  // stage 6: sum
  logic                     s6_v_r;
  logic [SUM_W-1:0]         sum_r;
  side_t                    s6_side_r;

  vert_t                    a, c;
  logic [4:0]               col;
  logic signed [PROD_W:0]   d0, d1, d2;
  logic signed [N_W-1:0]    nneg [3];

  always_comb begin
    a = (winding == WIND_SWAP) ? v2 : v0;
    c = (winding == WIND_SWAP) ? v0 : v2;
    if (palette[PAL_W-1]) begin
      col = 5'd0;
    end else if (palette[PAL_W-2:5] != '0) begin
      col = MAX_COLOR;
    end else begin
      col = palette[4:0];
    end
    d0 = {p0_r[PROD_W-1], p0_r} - {p1_r[PROD_W-1], p1_r};
    d1 = {p2_r[PROD_W-1], p2_r} - {p3_r[PROD_W-1], p3_r};
    d2 = {p4_r[PROD_W-1], p4_r} - {p5_r[PROD_W-1], p5_r};
    for (int i = 0; i < 3; i++) begin
      nneg[i] = -n_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // z is negated, so its edge runs the other way
      e1x_r      <= {v1.x[COORD_BITS-1], v1.x} - {a.x[COORD_BITS-1], a.x};
      e1y_r      <= {v1.y[COORD_BITS-1], v1.y} - {a.y[COORD_BITS-1], a.y};
      e1z_r      <= {a.z[COORD_BITS-1], a.z} - {v1.z[COORD_BITS-1], v1.z};
      e2x_r      <= {c.x[COORD_BITS-1], c.x} - {a.x[COORD_BITS-1], a.x};
      e2y_r      <= {c.y[COORD_BITS-1], c.y} - {a.y[COORD_BITS-1], a.y};
      e2z_r      <= {a.z[COORD_BITS-1], a.z} - {c.z[COORD_BITS-1], c.z};
      s1_cull_r  <= (winding != WIND_NOCULL);
      s1_shade_r <= SHADE_LUT[col];

      p0_r       <= e1y_r * e2z_r;
      p1_r       <= e1z_r * e2y_r;
      p2_r       <= e1z_r * e2x_r;
      p3_r       <= e1x_r * e2z_r;
      p4_r       <= e1x_r * e2y_r;
      p5_r       <= e1y_r * e2x_r;
      s2_cull_r  <= s1_cull_r;
      s2_shade_r <= s1_shade_r;

      n_r[0]     <= d0[N_W-1:0];
      n_r[1]     <= d1[N_W-1:0];
      n_r[2]     <= d2[N_W-1:0];
      s3_cull_r  <= s2_cull_r;
      s3_shade_r <= s2_shade_r;

      for (int i = 0; i < 3; i++) begin
        s4_side_r.neg[i] <= n_r[i][N_W-1];
        s4_side_r.mag[i] <= n_r[i][N_W-1] ? nneg[i][MAG_W-1:0] : n_r[i][MAG_W-1:0];
      end
      s4_side_r.cull  <= s3_cull_r;
      s4_side_r.shade <= s3_shade_r;

      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= s4_side_r.mag[i] * s4_side_r.mag[i];
      end
      s5_side_r <= s4_side_r;

      sum_r     <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      s6_side_r <= s5_side_r;
    end
  end

  assign out_v = s6_v_r;
  assign sum   = sum_r;
  assign side  = s6_side_r;

endmodule

/* hdl/tnss_sqrt.sv */
// Integer square root, one result bit per pipeline stage.
module tnss_sqrt import tnss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [SUM_W-1:0]  rad,
  input  side_t             in_side,
  output logic              out_v,
  output logic [ROOT_W-1:0] root,
  output side_t             out_side
);

  logic              v_r    [ROOT_W];
  logic [SUM_W-1:0]  rad_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              v_in;
    logic [SUM_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    side_t             side_in;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign rad_in  = rad;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in << 2;
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_v    = v_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

/* hdl/tnss_div.sv */
// Three-lane restoring divider, one quotient bit per pipeline stage.
module tnss_div import tnss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [ROOT_W-1:0] len,
  input  side_t             in_side,
  output logic              out_v,
  output logic [ROOT_W-1:0] out_len,
  output logic [2:0][Q_W-1:0] quot,
  output side_t             out_side
);

  logic                  v_r    [Q_W];
  logic [ROOT_W-1:0]     len_r  [Q_W];
  logic [2:0][DREM_W-1:0] rem_r [Q_W];
  logic [2:0][Q_W-1:0]   q_r    [Q_W];
  side_t                 side_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_st
    logic                   v_in;
    logic [ROOT_W-1:0]      len_in;
    logic [2:0][DREM_W-1:0] rem_in, rem_sh, rem_nxt;
    logic [2:0][Q_W-1:0]    q_in, q_nxt;
    side_t                  side_in;

    if (j == 0) begin : g_first
      // |component| never exceeds len, so the top bit needs no shift
      assign v_in    = in_v;
      assign len_in  = len;
      assign side_in = in_side;
      assign q_in    = '0;
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign rem_in[l] = DREM_W'(in_side.mag[l]);
        assign rem_sh[l] = rem_in[l];
      end
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign len_in  = len_r[j-1];
      assign side_in = side_r[j-1];
      assign q_in    = q_r[j-1];
      assign rem_in  = rem_r[j-1];
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign rem_sh[l] = rem_in[l] << 1;
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_sh[l] >= DREM_W'(len_in)) begin
          rem_nxt[l] = rem_sh[l] - DREM_W'(len_in);
          q_nxt[l]   = {q_in[l][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem_sh[l];
          q_nxt[l]   = {q_in[l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j]  <= len_in;
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_v    = v_r[Q_W-1];
  assign out_len  = len_r[Q_W-1];
  assign quot     = q_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

/* hdl/triangle_normal_shade_setup_unit.sv */
// Triangle face normal and shade setup: top level with output stage.
// Pipeline: 6 front stages, ROOT_W root stages (26), Q_W divide stages (15)
//   and 1 output stage between input word and output word.
// Throughput: one word per cycle; every stage advances together whenever the
//   output register is empty or being taken, so a stall freezes the whole pipe.
// Reset: synchronous, active-low rst_n clears all valid bits; data regs are not reset.
module triangle_normal_shade_setup_unit import tnss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz (12b each), winding (2b), palette (8b)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // normal_x, normal_y, normal_z (16b each), cull_enable (1b), shade (8b)
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready
);

  localparam logic [OUT_W:0] POS_MAX = (OUT_W+1)'((1 << (OUT_W - 1)) - 1);

  logic              adv;
  vert_t             v0, v1, v2;
  logic [WIND_W-1:0] winding;
  logic [PAL_W-1:0]  palette;

  logic              fr_v;
  logic [SUM_W-1:0]  fr_sum;
  side_t             fr_side;
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;
  logic              dv_v;
  logic [ROOT_W-1:0] dv_len;
  logic [2:0][Q_W-1:0] dv_q;
  side_t             dv_side;

  logic              out_v_r;
  logic [2:0][OUT_W-1:0] norm_r, norm_nxt;
  logic              cull_r;
  logic [SHADE_W-1:0] shade_r;

  // whole pipe moves when the output word is free or leaving;
  // no word is taken while reset holds the valid bits clear
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv && rst_n;

  // unpack input word
  assign v0.x    = in_tdata[0*COORD_BITS +: COORD_BITS];
  assign v0.y    = in_tdata[1*COORD_BITS +: COORD_BITS];
  assign v0.z    = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign v1.x    = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign v1.y    = in_tdata[4*COORD_BITS +: COORD_BITS];
  assign v1.z    = in_tdata[5*COORD_BITS +: COORD_BITS];
  assign v2.x    = in_tdata[6*COORD_BITS +: COORD_BITS];
  assign v2.y    = in_tdata[7*COORD_BITS +: COORD_BITS];
  assign v2.z    = in_tdata[8*COORD_BITS +: COORD_BITS];
  assign winding = in_tdata[9*COORD_BITS +: WIND_W];
  assign palette = in_tdata[9*COORD_BITS + WIND_W +: PAL_W];

  tnss_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (in_tvalid),
    .v0      (v0),
    .v1      (v1),
    .v2      (v2),
    .winding (winding),
    .palette (palette),
    .out_v   (fr_v),
    .sum     (fr_sum),
    .side    (fr_side)
  );

  tnss_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (fr_v),
    .rad      (fr_sum),
    .in_side  (fr_side),
    .out_v    (sq_v),
    .root     (sq_root),
    .out_side (sq_side)
  );

  tnss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (sq_v),
    .len      (sq_root),
    .in_side  (sq_side),
    .out_v    (dv_v),
    .out_len  (dv_len),
    .quot     (dv_q),
    .out_side (dv_side)
  );

  // sign, saturation at full scale, zero normal for a degenerate triangle
  always_comb begin
    logic [OUT_W:0] qe;
    logic [OUT_W:0] qn;
    for (int l = 0; l < 3; l++) begin
      qe = (OUT_W+1)'(dv_q[l]);
      qn = -qe;
      if (dv_len == '0) begin
        norm_nxt[l] = '0;
      end else if (dv_side.neg[l]) begin
        norm_nxt[l] = qn[OUT_W-1:0];
      end else if (qe > POS_MAX) begin
        norm_nxt[l] = POS_MAX[OUT_W-1:0];
      end else begin
        norm_nxt[l] = qe[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_r  <= norm_nxt;
      cull_r  <= dv_side.cull;
      shade_r <= dv_side.shade;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({shade_r, cull_r, norm_r[2], norm_r[1], norm_r[0]});

endmodule

/* tb/sv/triangle_normal_shade_setup_unit_tb.sv */
// Stream testbench for the triangle normal and shade setup unit.
`timescale 1ns / 100ps
module triangle_normal_shade_setup_unit_tb import tnss_pkg::*; ();

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;

  localparam logic [WIND_W-1:0] WIND_NORMAL = 2'b01;  // 1
  localparam logic [WIND_W-1:0] WIND_RESV   = 2'b10;  // -2, culls without swap

  localparam string NRM_NAME [3] = '{"normal_x", "normal_y", "normal_z"};

  // one triangle word as it goes into in_tdata
  typedef struct {
    logic signed [COORD_BITS-1:0] crd[9];  // ax ay az bx by bz cx cy cz
    logic signed [WIND_W-1:0]     winding;
    logic signed [PAL_W-1:0]      palette;
  } tri_t;

  // one expected result word
  typedef struct {
    logic [OUT_W-1:0]   nrm[3];
    logic               cull;
    logic [SHADE_W-1:0] shade;
  } shade_res_t;

  logic [IN_TDATA_W-1:0] tri_words[$];
  shade_res_t            expected_shading[$];
  int                    err_cnt;
  bit                    stim_done;

  triangle_normal_shade_setup_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(sqrt(n)), n below 2^52 here
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] unit_comp(longint c, longint unsigned len);
    longint unsigned m;
    longint unsigned q;
    longint v;
    m = (c < 0) ? longint'(-c) : longint'(c);
    q = (m << NORMAL_FRAC_BITS) / len;
    if (c < 0) v = -longint'(q);
    else v = (q > 32767) ? 32767 : longint'(q);
    return v[OUT_W-1:0];
  endfunction

  // face normal, cull flag and shade of one triangle
  function automatic shade_res_t face_shading(tri_t t);
    shade_res_t r;
    longint p[3][3];
    longint tmp;
    longint e1[3];
    longint e2[3];
    longint n[3];
    longint unsigned len;
    int col;
    for (int i = 0; i < 9; i++) p[i/3][i%3] = t.crd[i];
    if (t.winding == WIND_SWAP)
      for (int j = 0; j < 3; j++) begin
        tmp = p[0][j]; p[0][j] = p[2][j]; p[2][j] = tmp;
      end
    for (int i = 0; i < 3; i++) p[i][2] = -p[i][2];
    for (int j = 0; j < 3; j++) begin
      e1[j] = p[1][j] - p[0][j];
      e2[j] = p[2][j] - p[0][j];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    len = isqrt(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
    for (int i = 0; i < 3; i++) r.nrm[i] = (len == 0) ? '0 : unit_comp(n[i], len);
    r.cull = (t.winding != WIND_NOCULL);
    col = t.palette;
    if (col < 0) col = 0;
    if (col > MAX_COLOR) col = MAX_COLOR;
    r.shade = SHADE_SCALE_OF(col);
    return r;
  endfunction

  function automatic logic [SHADE_W-1:0] SHADE_SCALE_OF(int c);
    int s;
    s = (c * 255) / MAX_COLOR;
    return s[SHADE_W-1:0];
  endfunction

  // queue a triangle word and its prediction
  task automatic add_tri(tri_t t);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    for (int i = 0; i < 9; i++) w[i*COORD_BITS +: COORD_BITS] = t.crd[i];
    w[9*COORD_BITS +: WIND_W]        = t.winding;
    w[9*COORD_BITS+WIND_W +: PAL_W]  = t.palette;
    tri_words.push_back(w);
    expected_shading.push_back(face_shading(t));
  endtask

  function automatic logic [COORD_BITS-1:0] rand_crd(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
      1: return COORD_BITS'($urandom_range(0, 15) - 8);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WIND_W-1:0] rand_wind();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return WIND_RESV;
    if (k < 4) return WIND_SWAP;
    if (k < 7) return WIND_NOCULL;
    return WIND_NORMAL;
  endfunction

  // stimulus: directed corners, then random triangles
  initial begin
    tri_t t;
    int mode;
    stim_done = 0;
    // degenerate: all zero, all equal corners
    for (int i = 0; i < 9; i++) t.crd[i] = '0;
    t.winding = WIND_NORMAL; t.palette = 8'sd0; add_tri(t);
    for (int i = 0; i < 9; i++) t.crd[i] = 12'h7FF;
    t.winding = WIND_SWAP; t.palette = 8'sd31; add_tri(t);
    for (int i = 0; i < 9; i++) t.crd[i] = 12'h800;
    t.winding = WIND_NOCULL; t.palette = 8'sh80; add_tri(t);
    // collinear
    t.crd = '{0, 0, 0, 5, 5, 5, 10, 10, 10}; t.winding = WIND_RESV; t.palette = 8'sd127;
    add_tri(t);
    // axis-aligned unit triangles give full-scale components
    t.crd = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; t.winding = WIND_NORMAL; t.palette = -8'sd1;
    add_tri(t);
    t.crd = '{0, 0, 0, 0, 1, 0, 0, 0, 1}; t.winding = WIND_SWAP; t.palette = 8'sd32;
    add_tri(t);
    t.crd = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; t.winding = WIND_NOCULL; t.palette = 8'sd1;
    add_tri(t);
    t.crd = '{0, 0, 0, 0, 1, 0, 1, 0, 0}; t.winding = WIND_RESV; t.palette = 8'sd30;
    add_tri(t);
    // extreme spans
    t.crd = '{-2048, -2048, -2048, 2047, -2048, 2047, -2048, 2047, 2047};
    t.winding = WIND_NORMAL; t.palette = 8'sd15; add_tri(t);
    t.crd = '{2047, 2047, -2048, -2048, 2047, 2047, 2047, -2048, -2048};
    t.winding = WIND_SWAP; t.palette = 8'sd16; add_tri(t);
    t.crd = '{-2048, 2047, 0, 2047, 2047, -2048, 0, -2048, 2047};
    t.winding = WIND_NOCULL; t.palette = 8'sd7; add_tri(t);
    for (int p = -2; p < 34; p += 5) begin
      for (int i = 0; i < 9; i++) t.crd[i] = rand_crd(2);
      t.winding = rand_wind(); t.palette = PAL_W'(p); add_tri(t);
    end
    for (int k = 0; k < 1130; k++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++)
        t.crd[i] = rand_crd(mode == 0 ? $urandom_range(0, 2) : (mode < 3 ? 1 : 2));
      t.winding = rand_wind();
      t.palette = PAL_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 33) - 1);
      add_tri(t);
    end
    stim_done = 1;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // driver
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0 || tri_words.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        in_tdata  <= tri_words.pop_front();
        in_tvalid <= 1'b1;
        send_gap  <= gap_len();
      end
    end
  end

  // monitor: checks each result word and paces out_tready
  int stall;
  always @(posedge clk) begin
    shade_res_t exp_r;
    logic [OUT_W-1:0] got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall      <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_shading.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          err_cnt++;
        end else begin
          exp_r = expected_shading.pop_front();
          for (int i = 0; i < 3; i++) begin
            got = out_tdata[i*OUT_W +: OUT_W];
            if (got !== exp_r.nrm[i]) begin
              $error("%s: expected %0d, got %0d", NRM_NAME[i],
                     $signed(exp_r.nrm[i]), $signed(got));
              err_cnt++;
            end
          end
          if (out_tdata[3*OUT_W] !== exp_r.cull) begin
            $error("cull_enable: expected %0b, got %0b", exp_r.cull, out_tdata[3*OUT_W]);
            err_cnt++;
          end
          if (out_tdata[3*OUT_W+1 +: SHADE_W] !== exp_r.shade) begin
            $error("shade: expected %0d, got %0d", exp_r.shade,
                   out_tdata[3*OUT_W+1 +: SHADE_W]);
            err_cnt++;
          end
        end
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall      <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        stall      <= gap_len();
      end
    end
  end

  initial begin
    err_cnt = 0;
    rst_n   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && tri_words.size() == 0 && expected_shading.size() == 0);
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && expected_shading.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
hdl/tnss_pkg.sv
hdl/tnss_front.sv
hdl/tnss_sqrt.sv
hdl/tnss_div.sv
hdl/triangle_normal_shade_setup_unit.sv
tb/sv/triangle_normal_shade_setup_unit_tb.sv
